[rtl/drp_pkg.sv]
// types and constants shared by the dead reckoning propagator
package drp_pkg;

    typedef struct packed {
        logic signed [15:0] speed;
        logic        [15:0] time_step;
        logic signed [31:0] heading_in;
    } drp_in_t;

    typedef struct packed {
        logic signed [47:0] pos_east;
        logic signed [47:0] pos_north;
        logic signed [15:0] vel_east;
        logic signed [15:0] vel_north;
        logic signed [15:0] heading_out;
        logic               advanced;
    } drp_out_t;

    localparam int OUT_POS_W      = 48;
    localparam int HEAD_W         = 16;
    localparam int SPEED_W        = 16;
    localparam int DT_W           = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int ITER_PER_STAGE = 4;
    localparam int CORDIC_STAGES  = CORDIC_STEPS / ITER_PER_STAGE;

    localparam int XY_W   = 32;
    localparam int ANG_W  = 33;
    localparam int PROD_W = XY_W + SPEED_W + 1;
    localparam int INC_W  = SPEED_W + DT_W + 1 - 8;

    localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    localparam logic signed [XY_W-1:0]  CORDIC_GAIN   = 32'sd652032874;
    localparam logic signed [ANG_W-1:0] ANGLE_QUARTER = 33'sd1073741824;
    localparam logic signed [ANG_W-1:0] ANGLE_HALF    = 33'sd2147483648;

    localparam int VEL_SHIFT = 30;
    localparam logic signed [PROD_W-1:0] VEL_ROUND = PROD_W'(64'sd536870912);
    localparam logic signed [PROD_W-1:0] VEL_MAX   = PROD_W'(64'sd32767);
    localparam logic signed [PROD_W-1:0] VEL_MIN   = PROD_W'(-64'sd32768);

    localparam logic signed [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
    };

endpackage

[rtl/dead_reckoning_propagator_unit.sv]
// dead reckoning propagator: pipelined cordic velocity and saturating position update
//
//   channel  ports                        direction  payload
//   s_       s_valid s_ready s_data       in         drp_in_t  (speed, time_step, heading_in)
//   m_       m_valid m_ready m_data       out        drp_out_t (positions, velocities, heading)
//
// one transaction per cycle sustained while m_ready does not stall the output; an input passes
// in order through the input register, four cordic stages of four rotations each,
// the speed product register, the velocity/increment register and the result register
// aresetn clears all valid flags and the position and velocity state to zero
// every stage moves only while the result register is empty or being taken, so a
// stall on m_ready holds the whole pipeline and s_ready follows it
module dead_reckoning_propagator_unit #(
    parameter int POSITION_BITS = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  drp_pkg::drp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output drp_pkg::drp_out_t m_data
);
    import drp_pkg::*;

    localparam int SUM_W = POSITION_BITS + 1;

    logic pipe_en;

    logic                      in_valid_reg;
    logic signed [SPEED_W-1:0] in_speed_reg;
    logic        [DT_W-1:0]    in_dt_reg;
    logic        [HEAD_W-1:0]  in_head_reg;

    logic        [31:0]        phase;
    logic signed [ANG_W-1:0]   ang_raw;
    logic signed [ANG_W-1:0]   ang_red;
    logic                      flip_red;

    logic signed [XY_W-1:0]    cx_in    [CORDIC_STAGES];
    logic signed [XY_W-1:0]    cy_in    [CORDIC_STAGES];
    logic signed [ANG_W-1:0]   ca_in    [CORDIC_STAGES];
    logic signed [XY_W-1:0]    cx_out   [CORDIC_STAGES];
    logic signed [XY_W-1:0]    cy_out   [CORDIC_STAGES];
    logic signed [ANG_W-1:0]   ca_out   [CORDIC_STAGES];
    logic                      cflip_in [CORDIC_STAGES];
    logic signed [SPEED_W-1:0] cspd_in  [CORDIC_STAGES];
    logic        [DT_W-1:0]    cdt_in   [CORDIC_STAGES];
    logic        [HEAD_W-1:0]  chead_in [CORDIC_STAGES];
    logic                      cval_in  [CORDIC_STAGES];

    logic signed [XY_W-1:0]    cx_reg    [CORDIC_STAGES];
    logic signed [XY_W-1:0]    cy_reg    [CORDIC_STAGES];
    logic signed [ANG_W-1:0]   ca_reg    [CORDIC_STAGES];
    logic                      cflip_reg [CORDIC_STAGES];
    logic signed [SPEED_W-1:0] cspd_reg  [CORDIC_STAGES];
    logic        [DT_W-1:0]    cdt_reg   [CORDIC_STAGES];
    logic        [HEAD_W-1:0]  chead_reg [CORDIC_STAGES];
    logic                      cval_reg  [CORDIC_STAGES];

    logic signed [SPEED_W:0]   spd_adj;
    logic signed [PROD_W-1:0]  prod_c_next;
    logic signed [PROD_W-1:0]  prod_s_next;
    logic                      prod_valid_reg;
    logic signed [PROD_W-1:0]  prod_c_reg;
    logic signed [PROD_W-1:0]  prod_s_reg;
    logic        [DT_W-1:0]    prod_dt_reg;
    logic        [HEAD_W-1:0]  prod_head_reg;

    logic                      prod_adv;
    logic signed [SPEED_W-1:0] vel_e_reg;
    logic signed [SPEED_W-1:0] vel_n_reg;
    logic signed [SPEED_W-1:0] vel_e_next;
    logic signed [SPEED_W-1:0] vel_n_next;
    logic signed [DT_W:0]      dt_signed;
    logic signed [SPEED_W+DT_W:0] mul_e;
    logic signed [SPEED_W+DT_W:0] mul_n;
    logic signed [INC_W-1:0]   inc_e_next;
    logic signed [INC_W-1:0]   inc_n_next;

    logic                      fin_valid_reg;
    logic                      fin_adv_reg;
    logic        [HEAD_W-1:0]  fin_head_reg;
    logic signed [SPEED_W-1:0] fin_vel_e_reg;
    logic signed [SPEED_W-1:0] fin_vel_n_reg;
    logic signed [INC_W-1:0]   inc_e_reg;
    logic signed [INC_W-1:0]   inc_n_reg;

    logic signed [POSITION_BITS-1:0] pos_e_reg;
    logic signed [POSITION_BITS-1:0] pos_n_reg;
    logic signed [POSITION_BITS-1:0] pos_e_next;
    logic signed [POSITION_BITS-1:0] pos_n_next;
    logic signed [63:0]        pos_e_ext;
    logic signed [63:0]        pos_n_ext;

    logic                      out_valid_reg;
    drp_out_t                  out_data_reg;

    function automatic logic signed [SPEED_W-1:0] vel_round(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] r;
        r = (p + VEL_ROUND) >>> VEL_SHIFT;
        if (r > VEL_MAX) begin
            r = VEL_MAX;
        end else if (r < VEL_MIN) begin
            r = VEL_MIN;
        end
        return r[SPEED_W-1:0];
    endfunction

    function automatic logic signed [POSITION_BITS-1:0] pos_add(
        input logic signed [POSITION_BITS-1:0] p,
        input logic signed [INC_W-1:0]         inc
    );
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(p) + SUM_W'(inc);
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            if (sum[SUM_W-1]) begin
                return {1'b1, {(POSITION_BITS-1){1'b0}}};
            end else begin
                return {1'b0, {(POSITION_BITS-1){1'b1}}};
            end
        end
        return sum[POSITION_BITS-1:0];
    endfunction

    assign pipe_en = !out_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in_speed_reg <= s_data.speed;
            in_dt_reg    <= s_data.time_step;
            in_head_reg  <= s_data.heading_in[HEAD_W-1:0];
        end
    end

    // angle reduction to the right half plane
    always_comb begin
        phase    = {in_head_reg, 16'b0} & PHASE_KEEP;
        ang_raw  = ANG_W'($signed(phase));
        ang_red  = ang_raw;
        flip_red = 1'b0;
        if (ang_raw > ANGLE_QUARTER) begin
            ang_red  = ang_raw - ANGLE_HALF;
            flip_red = 1'b1;
        end else if (ang_raw < -ANGLE_QUARTER) begin
            ang_red  = ang_raw + ANGLE_HALF;
            flip_red = 1'b1;
        end
    end

    // cordic rotation stages
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        if (k == 0) begin : g_first
            assign cx_in[k]    = CORDIC_GAIN;
            assign cy_in[k]    = '0;
            assign ca_in[k]    = ang_red;
            assign cflip_in[k] = flip_red;
            assign cspd_in[k]  = in_speed_reg;
            assign cdt_in[k]   = in_dt_reg;
            assign chead_in[k] = in_head_reg;
            assign cval_in[k]  = in_valid_reg;
        end else begin : g_next
            assign cx_in[k]    = cx_reg[k-1];
            assign cy_in[k]    = cy_reg[k-1];
            assign ca_in[k]    = ca_reg[k-1];
            assign cflip_in[k] = cflip_reg[k-1];
            assign cspd_in[k]  = cspd_reg[k-1];
            assign cdt_in[k]   = cdt_reg[k-1];
            assign chead_in[k] = chead_reg[k-1];
            assign cval_in[k]  = cval_reg[k-1];
        end

        always_comb begin
            logic signed [XY_W-1:0]  x;
            logic signed [XY_W-1:0]  y;
            logic signed [XY_W-1:0]  nx;
            logic signed [ANG_W-1:0] a;
            x = cx_in[k];
            y = cy_in[k];
            a = ca_in[k];
            for (int i = 0; i < ITER_PER_STAGE; i++) begin
                if (!a[ANG_W-1]) begin
                    nx = x - (y >>> (k * ITER_PER_STAGE + i));
                    y  = y + (x >>> (k * ITER_PER_STAGE + i));
                    a  = a - ATAN_TURN[k * ITER_PER_STAGE + i];
                end else begin
                    nx = x + (y >>> (k * ITER_PER_STAGE + i));
                    y  = y - (x >>> (k * ITER_PER_STAGE + i));
                    a  = a + ATAN_TURN[k * ITER_PER_STAGE + i];
                end
                x = nx;
            end
            cx_out[k] = x;
            cy_out[k] = y;
            ca_out[k] = a;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cval_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                cval_reg[k] <= cval_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                cx_reg[k]    <= cx_out[k];
                cy_reg[k]    <= cy_out[k];
                ca_reg[k]    <= ca_out[k];
                cflip_reg[k] <= cflip_in[k];
                cspd_reg[k]  <= cspd_in[k];
                cdt_reg[k]   <= cdt_in[k];
                chead_reg[k] <= chead_in[k];
            end
        end
    end

    // speed times cosine and sine, half-turn flip folded into the speed sign
    always_comb begin
        spd_adj = (SPEED_W + 1)'(cspd_reg[CORDIC_STAGES-1]);
        if (cflip_reg[CORDIC_STAGES-1]) begin
            spd_adj = -spd_adj;
        end
        prod_c_next = spd_adj * cx_reg[CORDIC_STAGES-1];
        prod_s_next = spd_adj * cy_reg[CORDIC_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            prod_valid_reg <= cval_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_c_reg    <= prod_c_next;
            prod_s_reg    <= prod_s_next;
            prod_dt_reg   <= cdt_reg[CORDIC_STAGES-1];
            prod_head_reg <= chead_reg[CORDIC_STAGES-1];
        end
    end

    // velocity state and position increment from the previous velocity
    always_comb begin
        prod_adv   = prod_valid_reg && (prod_dt_reg != '0);
        vel_e_next = vel_e_reg;
        vel_n_next = vel_n_reg;
        if (prod_adv) begin
            vel_e_next = vel_round(prod_c_reg);
            vel_n_next = vel_round(prod_s_reg);
        end
        dt_signed  = $signed({1'b0, prod_dt_reg});
        mul_e      = vel_e_reg * dt_signed;
        mul_n      = vel_n_reg * dt_signed;
        inc_e_next = INC_W'((mul_e + (SPEED_W + DT_W + 1)'(128)) >>> 8);
        inc_n_next = INC_W'((mul_n + (SPEED_W + DT_W + 1)'(128)) >>> 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            vel_e_reg     <= '0;
            vel_n_reg     <= '0;
        end else if (pipe_en) begin
            fin_valid_reg <= prod_valid_reg;
            vel_e_reg     <= vel_e_next;
            vel_n_reg     <= vel_n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fin_adv_reg   <= prod_adv;
            fin_head_reg  <= prod_head_reg;
            fin_vel_e_reg <= vel_e_next;
            fin_vel_n_reg <= vel_n_next;
            inc_e_reg     <= inc_e_next;
            inc_n_reg     <= inc_n_next;
        end
    end

    // saturating position update
    always_comb begin
        pos_e_next = pos_e_reg;
        pos_n_next = pos_n_reg;
        if (fin_valid_reg && fin_adv_reg) begin
            pos_e_next = pos_add(pos_e_reg, inc_e_reg);
            pos_n_next = pos_add(pos_n_reg, inc_n_reg);
        end
        pos_e_ext = 64'(pos_e_next);
        pos_n_ext = 64'(pos_n_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_e_reg     <= '0;
            pos_n_reg     <= '0;
        end else if (pipe_en) begin
            out_valid_reg <= fin_valid_reg;
            pos_e_reg     <= pos_e_next;
            pos_n_reg     <= pos_n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_data_reg.pos_east    <= pos_e_ext[OUT_POS_W-1:0];
            out_data_reg.pos_north   <= pos_n_ext[OUT_POS_W-1:0];
            out_data_reg.vel_east    <= fin_vel_e_reg;
            out_data_reg.vel_north   <= fin_vel_n_reg;
            out_data_reg.heading_out <= $signed(fin_head_reg);
            out_data_reg.advanced    <= fin_adv_reg;
        end
    end

endmodule

[bench/dead_reckoning_propagator_unit_tb.sv]
// testbench for the dead reckoning propagator: directed and random steps checked against a predictor
`timescale 1ns / 100ps

module dead_reckoning_propagator_unit_tb;
    import drp_pkg::*;

    class drp_track_board;
        localparam longint POS_HI       = 64'sh0000_7FFF_FFFF_FFFF;
        localparam longint POS_LO       = -64'sh0000_8000_0000_0000;
        localparam longint QUARTER_TURN = 64'sd1073741824;
        localparam longint HALF_TURN    = 64'sd2147483648;
        localparam longint TRIG_START   = 64'sd652032874;
        localparam int     TRIG_BITS    = 16;
        localparam int     ROTATIONS    = 16;
        localparam logic [31:0] TRIG_KEEP = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
        localparam longint ARC_STEP [ROTATIONS] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861
        };

        drp_out_t pending_fixes[$];
        longint   east_pos, north_pos, east_vel, north_vel;
        int       bad_fields, steps_moved, steps_held, fixes_checked;

        function new();
            east_pos = 0;
            north_pos = 0;
            east_vel = 0;
            north_vel = 0;
            bad_fields = 0;
            steps_moved = 0;
            steps_held = 0;
            fixes_checked = 0;
        endfunction

        function longint clamp_pos(longint p);
            if (p > POS_HI) return POS_HI;
            if (p < POS_LO) return POS_LO;
            return p;
        endfunction

        function void heading_trig(logic [15:0] head, output longint c, output longint s);
            logic [31:0] phase;
            longint a, x, y, nx;
            bit flip;
            phase = {head, 16'h0000} & TRIG_KEEP;
            a = $signed(phase);
            flip = 0;
            if (a > QUARTER_TURN) begin
                a -= HALF_TURN;
                flip = 1;
            end else if (a < -QUARTER_TURN) begin
                a += HALF_TURN;
                flip = 1;
            end
            x = TRIG_START;
            y = 0;
            for (int i = 0; i < ROTATIONS; i++) begin
                if (a >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    a -= ARC_STEP[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    a += ARC_STEP[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint speed_times(longint spd, longint trig);
            longint v;
            v = (spd * trig + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void log_step(drp_in_t t);
            longint spd, dt, c, s;
            logic [15:0] head;
            drp_out_t fix;
            spd = t.speed;
            dt = t.time_step;
            head = t.heading_in[15:0];
            if (dt != 0) begin
                east_pos = clamp_pos(east_pos + ((east_vel * dt + 128) >>> 8));
                north_pos = clamp_pos(north_pos + ((north_vel * dt + 128) >>> 8));
                heading_trig(head, c, s);
                east_vel = speed_times(spd, c);
                north_vel = speed_times(spd, s);
                steps_moved++;
            end else begin
                steps_held++;
            end
            fix.pos_east = east_pos[47:0];
            fix.pos_north = north_pos[47:0];
            fix.vel_east = east_vel[15:0];
            fix.vel_north = north_vel[15:0];
            fix.heading_out = head;
            fix.advanced = (dt != 0);
            pending_fixes.push_back(fix);
        endfunction

        function void flag_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want) begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_report(drp_out_t got);
            drp_out_t want;
            if (pending_fixes.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("%0t result transaction with no step pending: %h", $time, got);
                return;
            end
            want = pending_fixes.pop_front();
            fixes_checked++;
            flag_field("pos_east", want.pos_east, got.pos_east);
            flag_field("pos_north", want.pos_north, got.pos_north);
            flag_field("vel_east", 48'(want.vel_east), 48'(got.vel_east));
            flag_field("vel_north", 48'(want.vel_north), 48'(got.vel_north));
            flag_field("heading_out", 48'(want.heading_out), 48'(got.heading_out));
            flag_field("advanced", 48'(want.advanced), 48'(got.advanced));
        endfunction

        function int pending();
            return pending_fixes.size();
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    drp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    drp_out_t m_data;
    bit       no_idle;

    drp_track_board board = new();

    dead_reckoning_propagator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.log_step(s_data);
            if (m_valid && m_ready)
                board.check_report(m_data);
        end
    end

    function automatic drp_in_t mk_step(int spd, int step, int head);
        drp_in_t t;
        t.speed = 16'(spd);
        t.time_step = 16'(step);
        t.heading_in = head;
        return t;
    endfunction

    task automatic send_step(drp_in_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // receiver side stalls
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        #5000000;
        $display("dead_reckoning_propagator_unit_tb: errors");
        $finish;
    end

    initial begin
        int dt_kind, spd, dt;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        no_idle = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed steps
        send_step(mk_step(0, 0, 0));
        send_step(mk_step(32767, 65535, 0));
        send_step(mk_step(-32768, 1, 0));
        send_step(mk_step(-32768, 65535, 32768));
        send_step(mk_step(256, 32768, 16384));
        send_step(mk_step(256, 32768, -16384));
        send_step(mk_step(32767, 0, 12345));
        send_step(mk_step(-32768, 65535, 32'h7FFF_FFFF));
        send_step(mk_step(32767, 65535, 32'h8000_0000));
        send_step(mk_step(1000, 65535, 16385));
        send_step(mk_step(1000, 1, -16385));
        send_step(mk_step(-1, 65535, 32767));
        send_step(mk_step(1, 1, -32767));
        send_step(mk_step(5000, 100, 32'h1234_8000));
        send_step(mk_step(-20000, 65535, 8192));
        send_step(mk_step(20000, 65535, 24576));
        send_step(mk_step(20000, 65535, -24576));
        send_step(mk_step(0, 65535, -8192));
        send_step(mk_step(0, 0, 0));
        send_step(mk_step(32767, 65535, 16384));
        send_step(mk_step(-32768, 65535, -16384));

        // random steps
        for (int n = 0; n < 1030; n++) begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            dt_kind = $urandom_range(0, 9);
            case (dt_kind)
                0: dt = 0;
                1: dt = 65535;
                2: dt = $urandom_range(1, 255);
                default: dt = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 9))
                0: spd = 32767;
                1: spd = -32768;
                default: spd = $urandom_range(0, 65535);
            endcase
            send_step(mk_step(spd, dt, $urandom));
        end
        s_valid = 1'b0;
        no_idle = 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d moving steps and %0d zero-step holds, %0d results compared",
                 board.steps_moved, board.steps_held, board.fixes_checked);
        $display("field mismatches seen: %0d", board.bad_fields);
        if (board.bad_fields == 0) begin
            $display("dead_reckoning_propagator_unit_tb: clean");
        end else begin
            $display("dead_reckoning_propagator_unit_tb: errors");
        end
        $finish;
    end

endmodule
